@@ rtl/svsm_pkg.sv @@
// Shared widths, reset values and reciprocal constants for the servo pulse smoother.
// Also defines the item passed from the target stage to the smoothing stage.
// No dependencies.
`default_nettype none

package svsm_pkg;

   localparam int WIDTH_BITS     = 13;
   localparam int ANGLE_BITS     = 8;
   localparam int PRODUCT_BITS   = WIDTH_BITS + ANGLE_BITS;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic [WIDTH_BITS-1:0] width_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_PULSE = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_PULSE = 8'd1;

   localparam logic [ANGLE_BITS-1:0] ANGLE_LIMIT  = 8'd180;
   localparam width_type             MIN_RESET    = 13'd2000;
   localparam width_type             MAX_RESET    = 13'd4000;
   localparam width_type             CENTER_WIDTH = 13'd3000;

   // Division by 180 of the span product: multiply by ceil(2^29 / 180) and shift.
   localparam int                 RECIP180_BITS  = 22;
   localparam int                 RECIP180_SHIFT = 29;
   localparam logic [RECIP180_BITS-1:0] RECIP180 = 22'd2982617;

   // Smoothing weights and division by ten: multiply by ceil(2^20 / 10) and shift.
   localparam int                 SUM_BITS      = 17;
   localparam int                 RECIP10_SHIFT = 20;
   localparam logic [SUM_BITS-1:0] RECIP10      = 17'd104858;
   localparam logic [SUM_BITS-1:0] KEEP_WEIGHT  = 17'd7;
   localparam logic [SUM_BITS-1:0] MOVE_WEIGHT  = 17'd3;

   typedef struct packed {
      logic      valid;
      logic      servo;
      width_type target;
   } target_item_type;

endpackage

`default_nettype wire

@@ rtl/servo_angle_to_pulse_smoother_unit.sv @@
// Servo angle to pulse width converter with exponential smoothing, top level.
// An item goes through the input, product, target and result registers in that order.
// Throughput: one item per cycle while rsp_stall is low; the limit is the per-servo
// read-modify-write of the width state with its reciprocal multiply for division by ten.
// Reset: limits return to 2000 and 4000 ticks, both servo widths to 3000, pipeline empty.
`default_nettype none

module servo_angle_to_pulse_smoother_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_mode,
   input  wire logic [svsm_pkg::ANGLE_BITS-1:0]       req_angle,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_servo_id,
   output svsm_pkg::width_type                        rsp_compare_value,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [svsm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [svsm_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import svsm_pkg::*;

   width_type             min_pulse_ff;
   width_type             max_pulse_ff;
   logic                  in_valid_ff;
   logic                  in_mode_ff;
   logic [ANGLE_BITS-1:0] in_angle_ff;
   logic                  in_ready;
   logic                  target_ready;
   logic                  smooth_ready;
   target_item_type       target_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff <= MIN_RESET;
         max_pulse_ff <= MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MIN_PULSE: min_pulse_ff <= csr_wdata[WIDTH_BITS-1:0];
            REG_MAX_PULSE: max_pulse_ff <= csr_wdata[WIDTH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign in_ready  = !in_valid_ff || target_ready;
   assign req_stall = !in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         in_mode_ff  <= req_mode;
         in_angle_ff <= req_angle;
      end
   end

   svsm_target u_target (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_mode   (in_mode_ff),
      .in_angle  (in_angle_ff),
      .min_pulse (min_pulse_ff),
      .max_pulse (max_pulse_ff),
      .in_ready  (target_ready),
      .out_item  (target_item),
      .out_ready (smooth_ready)
   );

   svsm_smooth u_smooth (
      .clock             (clock),
      .reset             (reset),
      .in_item           (target_item),
      .in_ready          (smooth_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_servo_id      (rsp_servo_id),
      .rsp_compare_value (rsp_compare_value)
   );

endmodule

`default_nettype wire

@@ rtl/svsm_target.sv @@
// Two-stage mapping of a clamped angle onto a target pulse width between the limits.
// Depends on svsm_pkg.
`default_nettype none

module svsm_target (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   input  wire logic                               in_mode,
   input  wire logic [svsm_pkg::ANGLE_BITS-1:0]    in_angle,
   input  wire svsm_pkg::width_type                min_pulse,
   input  wire svsm_pkg::width_type                max_pulse,
   output logic                                    in_ready,
   output svsm_pkg::target_item_type               out_item,
   input  wire logic                               out_ready
);
   import svsm_pkg::*;

   localparam int SCALED_BITS = PRODUCT_BITS + RECIP180_BITS;

   logic [ANGLE_BITS-1:0]   angle_clamped;
   width_type               span;
   logic [PRODUCT_BITS-1:0] product_in;
   logic [PRODUCT_BITS-1:0] product_ff;
   logic                    prod_valid_ff;
   logic                    prod_servo_ff;
   logic                    prod_ready;
   logic [SCALED_BITS-1:0]  scaled;
   width_type               quotient;
   logic [WIDTH_BITS:0]     target_sum;
   logic                    tgt_valid_ff;
   logic                    tgt_servo_ff;
   width_type               tgt_width_ff;
   logic                    tgt_ready;

   always_comb begin
      angle_clamped = (in_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : in_angle;
      span          = (max_pulse > min_pulse) ? (max_pulse - min_pulse) : '0;
      product_in    = PRODUCT_BITS'(span) * PRODUCT_BITS'(angle_clamped);
      scaled        = SCALED_BITS'(product_ff) * SCALED_BITS'(RECIP180);
      quotient      = scaled[RECIP180_SHIFT +: WIDTH_BITS];
      target_sum    = {1'b0, min_pulse} + {1'b0, quotient};
   end

   assign tgt_ready  = !tgt_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || tgt_ready;
   assign in_ready   = prod_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         tgt_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (tgt_ready) begin
            tgt_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && in_valid) begin
         product_ff    <= product_in;
         prod_servo_ff <= in_mode;
      end
      if (tgt_ready && prod_valid_ff) begin
         tgt_servo_ff <= prod_servo_ff;
         tgt_width_ff <= target_sum[WIDTH_BITS-1:0];
      end
   end

   assign out_item.valid  = tgt_valid_ff;
   assign out_item.servo  = tgt_servo_ff;
   assign out_item.target = tgt_width_ff;

endmodule

`default_nettype wire

@@ rtl/svsm_smooth.sv @@
// Per-servo width state, exponential smoothing towards the target and the result register.
// Depends on svsm_pkg.
`default_nettype none

module svsm_smooth (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire svsm_pkg::target_item_type in_item,
   output logic                          in_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_servo_id,
   output svsm_pkg::width_type           rsp_compare_value
);
   import svsm_pkg::*;

   localparam int SCALED_BITS = 2 * SUM_BITS;

   width_type              width_ff [2];
   width_type              old_width;
   logic [SUM_BITS-1:0]    weighted;
   logic [SCALED_BITS-1:0] scaled;
   width_type              width_in;
   logic                   load;
   logic                   rsp_valid_ff;
   logic                   servo_id_ff;
   width_type              compare_ff;

   always_comb begin
      old_width = width_ff[in_item.servo];
      weighted  = SUM_BITS'(old_width) * KEEP_WEIGHT + SUM_BITS'(in_item.target) * MOVE_WEIGHT;
      scaled    = SCALED_BITS'(weighted) * SCALED_BITS'(RECIP10);
      width_in  = scaled[RECIP10_SHIFT +: WIDTH_BITS];
   end

   assign in_ready = !rsp_valid_ff || !rsp_stall;
   assign load     = in_item.valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         width_ff[0]  <= CENTER_WIDTH;
         width_ff[1]  <= CENTER_WIDTH;
      end else begin
         if (in_ready) begin
            rsp_valid_ff <= in_item.valid;
         end
         if (load) begin
            width_ff[in_item.servo] <= width_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         servo_id_ff <= in_item.servo;
         compare_ff  <= width_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_servo_id      = servo_id_ff;
   assign rsp_compare_value = compare_ff;

   // Both servos start centred after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (width_ff[0] == CENTER_WIDTH && width_ff[1] == CENTER_WIDTH))
      else $error("servo widths not centred after reset");

   // A freshly loaded result matches the stored width of its servo.
   assert property (@(posedge clock) disable iff (reset)
      $past(load) |-> (width_ff[rsp_servo_id] == rsp_compare_value))
      else $error("result differs from stored servo width");

   // The smoothed width never rises above the larger of the old width and the target.
   assert property (@(posedge clock) disable iff (reset)
      load |-> (width_in <= ((old_width > in_item.target) ? old_width : in_item.target)))
      else $error("smoothed width overshoots");

endmodule

`default_nettype wire

@@ tb/servo_width_checker.sv @@
// Checker for the servo pulse smoother: watches the item, result and register channels,
// predicts every compare value and counts each mismatching field and each unexpected result.
// Depends on svsm_pkg for widths and reset values.

module servo_width_checker
   import svsm_pkg::*;
#(
   parameter int MIN_PULSE_INDEX = int'(REG_MIN_PULSE),
   parameter int MAX_PULSE_INDEX = int'(REG_MAX_PULSE)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_stall,
   input  wire logic                      req_mode,
   input  wire logic [ANGLE_BITS-1:0]     req_angle,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire logic                      rsp_servo_id,
   input  wire width_type                 rsp_compare_value,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                             mismatch_count,
   output int                             outstanding_count
);

   localparam int WEIGHT_SUM = 10;

   typedef struct packed {
      logic      servo;
      width_type width;
   } compare_update_type;

   width_type          min_ticks;
   width_type          max_ticks;
   width_type          servo_width [2];
   compare_update_type expected_updates [$];
   int                 mismatches = 0;

   function automatic width_type pulse_target(input logic [ANGLE_BITS-1:0] angle);
      logic [ANGLE_BITS-1:0]   clamped;
      width_type               span;
      logic [PRODUCT_BITS-1:0] scaled;
      clamped = (angle > ANGLE_LIMIT) ? ANGLE_LIMIT : angle;
      span    = (max_ticks > min_ticks) ? width_type'(max_ticks - min_ticks) : '0;
      scaled  = span * clamped;
      return width_type'(min_ticks + scaled / ANGLE_LIMIT);
   endfunction

   function automatic width_type smoothed_width(input width_type old, input width_type target);
      logic [SUM_BITS-1:0] blend;
      blend = old * KEEP_WEIGHT + target * MOVE_WEIGHT;
      return width_type'(blend / WEIGHT_SUM);
   endfunction

   always @(posedge clock) begin : watch
      compare_update_type due;
      compare_update_type update;
      if (reset) begin
         min_ticks = MIN_RESET;
         max_ticks = MAX_RESET;
         servo_width[0] = CENTER_WIDTH;
         servo_width[1] = CENTER_WIDTH;
         expected_updates.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == MIN_PULSE_INDEX) begin
               min_ticks = width_type'(csr_wdata);
            end else if (csr_index == MAX_PULSE_INDEX) begin
               max_ticks = width_type'(csr_wdata);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_updates.size() == 0) begin
               mismatches++;
               $display("%0t: result with no item outstanding: servo_id %0d compare_value %0d",
                        $time, rsp_servo_id, rsp_compare_value);
            end else begin
               due = expected_updates.pop_front();
               if (rsp_servo_id !== due.servo) begin
                  mismatches++;
                  $display("%0t: servo_id expected %0d actual %0d",
                           $time, due.servo, rsp_servo_id);
               end
               if (rsp_compare_value !== due.width) begin
                  mismatches++;
                  $display("%0t: compare_value expected %0d actual %0d",
                           $time, due.width, rsp_compare_value);
               end
            end
         end
         if (req_valid && !req_stall) begin
            update.servo = req_mode;
            update.width = smoothed_width(servo_width[req_mode], pulse_target(req_angle));
            servo_width[req_mode] = update.width;
            expected_updates.push_back(update);
         end
      end
      mismatch_count    <= mismatches;
      outstanding_count <= expected_updates.size();
   end

endmodule

@@ tb/tb_top.sv @@
// Top of the servo pulse smoother testbench: clock, reset, item and register stimulus,
// receiver stalls and the verdict. Depends on svsm_pkg, the block and servo_width_checker.

module tb_top;
   import svsm_pkg::*;

   localparam int MIN_PULSE_INDEX = int'(REG_MIN_PULSE);
   localparam int MAX_PULSE_INDEX = int'(REG_MAX_PULSE);
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_ITEMS    = 1900;
   localparam int PHASE_COUNT     = 8;
   localparam int LONG_HOLD       = 300;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HOLD} stall_style_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_mode = 1'b0;
   logic [ANGLE_BITS-1:0]     req_angle = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_servo_id;
   width_type                 rsp_compare_value;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   int                        mismatch_count;
   int                        outstanding_count;
   int                        cycle_count = 0;
   logic                      random_started = 1'b0;

   servo_angle_to_pulse_smoother_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_angle         (req_angle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_servo_id      (rsp_servo_id),
      .rsp_compare_value (rsp_compare_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   servo_width_checker #(
      .MIN_PULSE_INDEX (MIN_PULSE_INDEX),
      .MAX_PULSE_INDEX (MAX_PULSE_INDEX)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_angle         (req_angle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_servo_id      (rsp_servo_id),
      .rsp_compare_value (rsp_compare_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("servo_angle_to_pulse_smoother_unit: mismatch");
      $finish;
   end

   // The first segment after the random items start is a long hold, so that the block
   // fills up and stalls its input; later holds come at random.
   initial begin
      stall_style_type style;
      int              seg_len;
      int              holds_done;
      holds_done = 0;
      forever begin
         if (random_started && holds_done == 0 || $urandom_range(0, 24) == 0) begin
            style = STALL_HOLD;
         end else begin
            style = stall_style_type'($urandom_range(0, 2));
         end
         if (style == STALL_HOLD && random_started) begin
            holds_done++;
         end
         seg_len = (style == STALL_HOLD) ? LONG_HOLD : $urandom_range(10, 80);
         for (int c = 0; c < seg_len; c++) begin
            @(posedge clock);
            case (style)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 40);
               STALL_PERIODIC: rsp_stall <= (c % 4 == 3);
               default:        rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   task automatic offer_item(input logic servo, input logic [ANGLE_BITS-1:0] angle);
      req_valid <= 1'b1;
      req_mode  <= servo;
      req_angle <= angle;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_until_idle;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input int index, input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= CSR_INDEX_BITS'(index);
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // The upper data bits carry random noise, which the block must drop.
   task automatic set_limits(input width_type min_value, input width_type max_value);
      write_register($urandom_range(MAX_PULSE_INDEX + 1, 255), CSR_DATA_BITS'($urandom));
      write_register(MIN_PULSE_INDEX, {3'($urandom), min_value});
      write_register(MAX_PULSE_INDEX, {3'($urandom), max_value});
   endtask

   function automatic logic [ANGLE_BITS-1:0] random_angle;
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
         return ANGLE_BITS'($urandom_range(0, 180));
      end else if (pick < 16) begin
         return ANGLE_BITS'($urandom_range(181, 255));
      end
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return 8'd180;
         2:       return 8'd181;
         default: return 8'd255;
      endcase
   endfunction

   initial begin
      width_type min_value;
      width_type max_value;
      int        per_phase;
      int        burst_left;
      int        gap;
      logic      servo;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      offer_item(1'b0, 8'd0);
      offer_item(1'b0, 8'd180);
      offer_item(1'b0, 8'd181);
      offer_item(1'b0, 8'd255);
      offer_item(1'b0, 8'd90);
      offer_item(1'b1, 8'd1);
      offer_item(1'b1, 8'd179);
      offer_item(1'b1, 8'd85);
      offer_item(1'b1, 8'd170);
      offer_item(1'b0, 8'd127);
      offer_item(1'b1, 8'd128);
      wait_until_idle();
      set_limits(13'd4000, 13'd1000);
      offer_item(1'b0, 8'd90);
      offer_item(1'b1, 8'd255);
      wait_until_idle();
      set_limits(13'd0, 13'd8191);
      offer_item(1'b0, 8'd255);
      offer_item(1'b0, 8'd180);
      offer_item(1'b1, 8'd0);
      offer_item(1'b1, 8'd179);
      wait_until_idle();

      random_started = 1'b1;
      per_phase  = RANDOM_ITEMS / PHASE_COUNT;
      burst_left = 0;
      servo      = 1'b0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       begin min_value = 13'd0;    max_value = 13'd8191; end
            1:       begin min_value = 13'd8191; max_value = 13'd0;    end
            2:       begin min_value = 13'd0;    max_value = 13'd0;    end
            3:       begin min_value = 13'd8191; max_value = 13'd8191; end
            4:       begin min_value = 13'd1000; max_value = 13'd6553; end
            5:       begin min_value = MIN_RESET; max_value = MAX_RESET; end
            default: begin
               min_value = width_type'($urandom_range(0, 8191));
               max_value = width_type'($urandom_range(0, 8191));
            end
         endcase
         set_limits(min_value, max_value);
         for (int n = 0; n < per_phase; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            burst_left--;
            if ($urandom_range(0, 1)) begin
               servo = 1'($urandom_range(0, 1));
            end
            offer_item(servo, random_angle());
         end
         wait_until_idle();
      end

      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("servo_angle_to_pulse_smoother_unit: match");
      end else begin
         $display("servo_angle_to_pulse_smoother_unit: mismatch");
      end
      $finish;
   end

endmodule
